FILE: design/tagged_value_table_macros.svh
// assertion macros for the tagged value table
`ifndef TAGGED_VALUE_TABLE_MACROS_SVH
`define TAGGED_VALUE_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TVT_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tagged_value_table: check failed");

// next-cycle implication
`define TVT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tagged_value_table: check failed");

`else

`define TVT_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define TVT_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/tvt_pkg.sv
`default_nettype none

package tvt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int DATA_W          = 64;

    localparam logic [DATA_W-1:0] U64_MAX = {DATA_W{1'b1}};

    // request opcodes
    typedef enum logic [2:0] {
        OP_SET      = 3'd0,
        OP_ADD      = 3'd1,
        OP_CLEAR    = 3'd2,
        OP_LOOKUP   = 3'd3,
        OP_SNAPSHOT = 3'd4,
        OP_FLUSH    = 3'd5
    } t_opcode;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FOUND   = 2'd1,
        ST_NONE    = 2'd2,
        ST_REFUSED = 2'd3
    } t_status;

    // request sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // one slot of the table memory
    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
        logic              present;
    } t_slot;

    // add that sticks at the all-ones value
    function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[DATA_W] ? U64_MAX : sum[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/tvt_ram.sv
`default_nettype none

module tvt_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output      logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/tagged_value_table.sv
// Tagged value table: up to TABLE_DEPTH (key, 64-bit value) slots held in one
// single-port-read, single-port-write memory. A new key takes the first cleared
// slot in use, else is appended at the end. Every request except flush and
// unused opcodes walks the slots in use from slot 0, one read per cycle through
// the memory read port unless a snapshot is paused, then posts its results; set,
// add and clear also do at most one write-back. Set, add, clear and lookup stop
// at the first slot whose key matches; a miss or a snapshot walks all slots in use.
// The final result also waits while an earlier result sits stalled in the output
// register, and a snapshot pauses while its results sit stalled at the output.
// One request is worked on at a time, and its write-back lands before the next
// request reads, so no forwarding is needed. The output register lets a new
// request be taken while the previous final result still waits.
`default_nettype none

`include "tagged_value_table_macros.svh"

module tagged_value_table #(
    parameter int TABLE_DEPTH = tvt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [63:0] i_tag_key,
    input  wire logic [63:0] i_operand,
    // result channel
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic [1:0]  o_status,
    output      logic [63:0] o_out_key,
    output      logic [63:0] o_out_value,
    output      logic        o_last
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = $bits(tvt_pkg::t_slot);
    localparam int DW = tvt_pkg::DATA_W;

    tvt_pkg::t_state  r_state, n_state;
    logic [2:0]       r_op, n_op;
    logic [DW-1:0]    r_key, n_key;
    logic [DW-1:0]    r_operand, n_operand;
    logic [CW-1:0]    r_used, n_used;
    logic [CW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_chk_valid, n_chk_valid;
    logic [IW-1:0]    r_chk_idx, n_chk_idx;
    logic             r_ent_valid, n_ent_valid;
    logic             r_ent_present, n_ent_present;
    logic [IW-1:0]    r_ent_idx, n_ent_idx;
    logic [DW-1:0]    r_ent_key, n_ent_key;
    logic [DW-1:0]    r_ent_value, n_ent_value;
    logic             r_free_valid, n_free_valid;
    logic [IW-1:0]    r_free_idx, n_free_idx;

    logic             r_out_valid, n_out_valid;
    tvt_pkg::t_status r_out_status, n_out_status;
    logic [DW-1:0]    r_out_key, n_out_key;
    logic [DW-1:0]    r_out_value, n_out_value;
    logic             r_out_last, n_out_last;

    logic             out_free;
    logic             emit;
    tvt_pkg::t_status emit_status;
    logic [DW-1:0]    emit_key;
    logic [DW-1:0]    emit_value;
    logic             emit_last;
    logic             scan_hold;
    logic             key_hit;

    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    tvt_pkg::t_slot   ram_wdata;
    logic             ram_re;
    tvt_pkg::t_slot   ram_rdata;
    logic [SW-1:0]    ram_rdata_raw;

    // slot memory
    tvt_ram #(
        .WIDTH (SW),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = tvt_pkg::t_slot'(ram_rdata_raw);

    // output register can take a transaction this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != tvt_pkg::S_IDLE);
    assign key_hit    = (ram_rdata.key == r_key);

    // a snapshot entry that needs to push out the pending one waits for room
    assign scan_hold = r_chk_valid && (r_op == tvt_pkg::OP_SNAPSHOT) && ram_rdata.present
                       && r_ent_valid && !out_free;

    // sequencer: next state, memory access and result generation
    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_key         = r_key;
        n_operand     = r_operand;
        n_used        = r_used;
        n_rd_idx      = r_rd_idx;
        n_chk_valid   = r_chk_valid;
        n_chk_idx     = r_chk_idx;
        n_ent_valid   = r_ent_valid;
        n_ent_present = r_ent_present;
        n_ent_idx     = r_ent_idx;
        n_ent_key     = r_ent_key;
        n_ent_value   = r_ent_value;
        n_free_valid  = r_free_valid;
        n_free_idx    = r_free_idx;

        emit        = 1'b0;
        emit_status = tvt_pkg::ST_DONE;
        emit_key    = '0;
        emit_value  = '0;
        emit_last   = 1'b1;

        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_ent_idx;
        ram_wdata = '{key: r_key, value: r_operand, present: 1'b1};

        case (r_state)
            tvt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op         = i_opcode;
                    n_key        = i_tag_key;
                    n_operand    = i_operand;
                    n_rd_idx     = '0;
                    n_chk_valid  = 1'b0;
                    n_ent_valid  = 1'b0;
                    n_free_valid = 1'b0;
                    if (i_opcode inside {tvt_pkg::OP_SET, tvt_pkg::OP_ADD, tvt_pkg::OP_CLEAR,
                                         tvt_pkg::OP_LOOKUP, tvt_pkg::OP_SNAPSHOT}) begin
                        n_state = tvt_pkg::S_SCAN;
                    end else begin
                        n_state = tvt_pkg::S_FINISH;
                    end
                end
            end

            tvt_pkg::S_SCAN: begin
                if (!scan_hold) begin
                    // issue the next read while slots in use remain
                    if (r_rd_idx < r_used) begin
                        ram_re      = 1'b1;
                        n_rd_idx    = CW'(r_rd_idx + 1'b1);
                        n_chk_valid = 1'b1;
                        n_chk_idx   = r_rd_idx[IW-1:0];
                    end else begin
                        n_chk_valid = 1'b0;
                    end

                    if (!r_chk_valid && (r_rd_idx >= r_used)) begin
                        n_state = tvt_pkg::S_FINISH;
                    end

                    // check the slot that came back from memory
                    if (r_chk_valid) begin
                        if (r_op == tvt_pkg::OP_SNAPSHOT) begin
                            if (ram_rdata.present) begin
                                if (r_ent_valid) begin
                                    emit        = 1'b1;
                                    emit_status = tvt_pkg::ST_FOUND;
                                    emit_key    = r_ent_key;
                                    emit_value  = r_ent_value;
                                    emit_last   = 1'b0;
                                end
                                n_ent_valid = 1'b1;
                                n_ent_key   = ram_rdata.key;
                                n_ent_value = ram_rdata.value;
                            end
                        end else if (key_hit) begin
                            n_ent_valid   = 1'b1;
                            n_ent_present = ram_rdata.present;
                            n_ent_idx     = r_chk_idx;
                            n_ent_value   = ram_rdata.value;
                            n_chk_valid   = 1'b0;
                            n_state       = tvt_pkg::S_FINISH;
                        end else if (!ram_rdata.present && !r_free_valid) begin
                            n_free_valid = 1'b1;
                            n_free_idx   = r_chk_idx;
                        end
                    end
                end
            end

            tvt_pkg::S_FINISH: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = tvt_pkg::S_IDLE;
                    case (r_op)
                        tvt_pkg::OP_SET, tvt_pkg::OP_ADD: begin
                            if (r_ent_valid) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_ent_idx;
                                if ((r_op == tvt_pkg::OP_ADD) && r_ent_present) begin
                                    ram_wdata.value = tvt_pkg::sat_add(r_ent_value, r_operand);
                                end
                            end else if (r_free_valid) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_free_idx;
                            end else if (r_used < CW'(TABLE_DEPTH)) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_used[IW-1:0];
                                n_used    = CW'(r_used + 1'b1);
                            end else begin
                                emit_status = tvt_pkg::ST_REFUSED;
                            end
                        end
                        tvt_pkg::OP_CLEAR: begin
                            if (r_ent_valid) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_ent_idx;
                                ram_wdata = '{key: r_key, value: r_ent_value, present: 1'b0};
                            end
                        end
                        tvt_pkg::OP_LOOKUP: begin
                            if (r_ent_valid && r_ent_present) begin
                                emit_status = tvt_pkg::ST_FOUND;
                                emit_value  = r_ent_value;
                            end else begin
                                emit_status = tvt_pkg::ST_NONE;
                            end
                        end
                        tvt_pkg::OP_SNAPSHOT: begin
                            if (r_ent_valid) begin
                                emit_status = tvt_pkg::ST_FOUND;
                                emit_key    = r_ent_key;
                                emit_value  = r_ent_value;
                            end else begin
                                emit_status = tvt_pkg::ST_NONE;
                            end
                        end
                        tvt_pkg::OP_FLUSH: begin
                            n_used = '0;
                        end
                        default: begin
                            emit_status = tvt_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            default: begin
                n_state = tvt_pkg::S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_key    = r_out_key;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;
        if (emit) begin
            n_out_valid  = 1'b1;
            n_out_status = emit_status;
            n_out_key    = emit_key;
            n_out_value  = emit_value;
            n_out_last   = emit_last;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tvt_pkg::S_IDLE;
            r_used       <= '0;
            r_chk_valid  <= 1'b0;
            r_ent_valid  <= 1'b0;
            r_free_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_chk_valid  <= n_chk_valid;
            r_ent_valid  <= n_ent_valid;
            r_free_valid <= n_free_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_key         <= n_key;
        r_operand     <= n_operand;
        r_rd_idx      <= n_rd_idx;
        r_chk_idx     <= n_chk_idx;
        r_ent_present <= n_ent_present;
        r_ent_idx     <= n_ent_idx;
        r_ent_key     <= n_ent_key;
        r_ent_value   <= n_ent_value;
        r_free_idx    <= n_free_idx;
        r_out_status  <= n_out_status;
        r_out_key     <= n_out_key;
        r_out_value   <= n_out_value;
        r_out_last    <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_out_key   = r_out_key;
    assign o_out_value = r_out_value;
    assign o_last      = r_out_last;

    // checks
    `TVT_ASSERT_NOW(a_we_only_at_finish, i_clk, i_rst_n, ram_we,
        (r_state == tvt_pkg::S_FINISH) && (r_op != tvt_pkg::OP_SNAPSHOT)
        && (r_op != tvt_pkg::OP_LOOKUP))
    `TVT_ASSERT_NEXT(a_finish_returns_idle, i_clk, i_rst_n,
        (r_state == tvt_pkg::S_FINISH) && out_free,
        (r_state == tvt_pkg::S_IDLE) && r_out_valid && r_out_last)
    `TVT_ASSERT_NEXT(a_used_steps, i_clk, i_rst_n, 1'b1,
        (r_used == $past(r_used)) || (r_used == $past(r_used) + 1'b1) || (r_used == '0))
    `TVT_ASSERT_NOW(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= CW'(TABLE_DEPTH))

endmodule

`default_nettype wire

FILE: dv/tagged_value_table_tb.sv
`timescale 1ns / 1ps

module tagged_value_table_tb;

    localparam int TABLE_DEPTH      = tvt_pkg::TABLE_DEPTH_DEF;
    localparam int KEY_POOL_SIZE    = 20;
    localparam int RANDOM_ITEMS     = 210;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int END_SETTLE       = 40;
    localparam int CYCLE_LIMIT      = 400000;

    // opcode codes that the block ignores
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    // one result transaction
    typedef struct {
        tvt_pkg::t_status status;
        logic [63:0]      key;
        logic [63:0]      value;
        logic             last;
    } t_result;

    // table predictor and queue of expected results
    class t_scoreboard;
        logic [63:0] slot_key     [TABLE_DEPTH];
        logic [63:0] slot_value   [TABLE_DEPTH];
        logic        slot_present [TABLE_DEPTH];
        int          used_count       = 0;
        t_result     expected_q [$];
        int          errors           = 0;
        int          requests_seen    = 0;
        int          results_seen     = 0;
        int          snapshot_entries = 0;
        int          refused_writes   = 0;
        int          saturated_adds   = 0;

        function void push_result(tvt_pkg::t_status status, logic [63:0] key,
                                  logic [63:0] value, logic last);
            t_result res;
            res.status = status;
            res.key    = key;
            res.value  = value;
            res.last   = last;
            expected_q.push_back(res);
        endfunction

        // first slot in use holding the key, -1 when none
        function int find_slot(logic [63:0] key);
            for (int i = 0; i < used_count; i++)
                if (slot_key[i] == key) return i;
            return -1;
        endfunction

        // set or saturating add, reusing a cleared slot or appending one
        function tvt_pkg::t_status write_slot(logic [2:0] opcode, logic [63:0] key,
                                              logic [63:0] operand);
            int          idx;
            logic [63:0] base;
            logic [64:0] sum;
            idx = find_slot(key);
            if (idx < 0) begin
                for (int i = 0; i < used_count && idx < 0; i++)
                    if (!slot_present[i]) idx = i;
                if (idx >= 0) begin
                    slot_key[idx] = key;
                end else if (used_count < TABLE_DEPTH) begin
                    idx               = used_count;
                    slot_key[idx]     = key;
                    slot_value[idx]   = '0;
                    slot_present[idx] = 1'b0;
                    used_count++;
                end else begin
                    refused_writes++;
                    return tvt_pkg::ST_REFUSED;
                end
            end
            if (opcode == tvt_pkg::OP_SET) begin
                slot_value[idx] = operand;
            end else begin
                base = slot_present[idx] ? slot_value[idx] : '0;
                sum  = {1'b0, base} + {1'b0, operand};
                if (sum[64]) saturated_adds++;
                slot_value[idx] = sum[64] ? tvt_pkg::U64_MAX : sum[63:0];
            end
            slot_present[idx] = 1'b1;
            return tvt_pkg::ST_DONE;
        endfunction

        // accepted request: update the table and queue its results
        function void note_request(logic [2:0] opcode, logic [63:0] key,
                                   logic [63:0] operand);
            int idx;
            int last_idx;
            requests_seen++;
            case (opcode)
                tvt_pkg::OP_SET, tvt_pkg::OP_ADD: begin
                    push_result(write_slot(opcode, key, operand), '0, '0, 1'b1);
                end
                tvt_pkg::OP_CLEAR: begin
                    idx = find_slot(key);
                    if (idx >= 0) slot_present[idx] = 1'b0;
                    push_result(tvt_pkg::ST_DONE, '0, '0, 1'b1);
                end
                tvt_pkg::OP_LOOKUP: begin
                    idx = find_slot(key);
                    if (idx >= 0 && slot_present[idx])
                        push_result(tvt_pkg::ST_FOUND, '0, slot_value[idx], 1'b1);
                    else
                        push_result(tvt_pkg::ST_NONE, '0, '0, 1'b1);
                end
                tvt_pkg::OP_SNAPSHOT: begin
                    last_idx = -1;
                    for (int i = 0; i < used_count; i++)
                        if (slot_present[i]) last_idx = i;
                    if (last_idx < 0) begin
                        push_result(tvt_pkg::ST_NONE, '0, '0, 1'b1);
                    end else begin
                        for (int i = 0; i <= last_idx; i++) begin
                            if (slot_present[i]) begin
                                push_result(tvt_pkg::ST_FOUND, slot_key[i], slot_value[i],
                                            i == last_idx);
                                snapshot_entries++;
                            end
                        end
                    end
                end
                tvt_pkg::OP_FLUSH: begin
                    used_count = 0;
                    push_result(tvt_pkg::ST_DONE, '0, '0, 1'b1);
                end
                default: begin
                    push_result(tvt_pkg::ST_DONE, '0, '0, 1'b1);
                end
            endcase
        endfunction

        // accepted result: compare with the oldest expectation
        function void check_result(logic [1:0] status, logic [63:0] key, logic [63:0] value,
                                   logic last);
            t_result want;
            results_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result status=%0d key=%h value=%h last=%b",
                         $time, status, key, value, last);
                return;
            end
            want = expected_q.pop_front();
            if (status !== want.status) begin
                errors++;
                $display("%0t: status mismatch expected %0d actual %0d",
                         $time, want.status, status);
            end
            if (key !== want.key) begin
                errors++;
                $display("%0t: key mismatch expected %h actual %h", $time, want.key, key);
            end
            if (value !== want.value) begin
                errors++;
                $display("%0t: value mismatch expected %h actual %h",
                         $time, want.value, value);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: last mismatch expected %b actual %b", $time, want.last, last);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [2:0]  i_opcode    = '0;
    logic [63:0] i_tag_key   = '0;
    logic [63:0] i_operand   = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [63:0] o_out_key;
    logic [63:0] o_out_value;
    logic        o_last;

    t_scoreboard         tvt_sb;
    logic [63:0]         key_pool [KEY_POOL_SIZE];
    bit                  quiet_mode    = 1'b0;
    bit                  long_hold_req = 1'b0;
    int                  burst_left    = 0;
    int                  items_sent    = 0;
    int                  cycle_count   = 0;

    tagged_value_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_opcode   (i_opcode),
        .i_tag_key  (i_tag_key),
        .i_operand  (i_operand),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status   (o_status),
        .o_out_key  (o_out_key),
        .o_out_value(o_out_value),
        .o_last     (o_last)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, tvt_sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tvt_sb.check_result(o_status, o_out_key, o_out_value, o_last);
    end

    // output backpressure, with one long hold-off on request
    initial begin : out_stall_gen
        int unsigned run;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (quiet_mode) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                  : $urandom_range(1, 3);
                i_out_stall <= ($urandom_range(0, 2) == 0);
                repeat (run) @(posedge i_clk);
            end
        end
    end

    // idle cycles after a request transaction
    function automatic int next_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if (quiet_mode) return 0;
        r = $urandom_range(0, 19);
        if (r < 10) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] pick_key();
        if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 4))
            0:       return {$urandom, $urandom};
            1:       return 64'($urandom_range(0, 255));
            2:       return tvt_pkg::U64_MAX - 64'($urandom_range(0, 255));
            3:       return {$urandom, $urandom} >> $urandom_range(0, 63);
            default: return ($urandom_range(0, 1) == 0) ? '0 : tvt_pkg::U64_MAX;
        endcase
    endfunction

    // offer one request, wait for its transaction, then idle a while
    task automatic send_request(input logic [2:0] opcode, input logic [63:0] key,
                                input logic [63:0] operand);
        int gap;
        i_in_valid <= 1'b1;
        i_opcode   <= opcode;
        i_tag_key  <= key;
        i_operand  <= operand;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        tvt_sb.note_request(opcode, key, operand);
        items_sent++;
        gap = next_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold the request side until every expected result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tvt_sb.pending() != 0) @(posedge i_clk);
    endtask

    // empty the table, fill it with fresh keys, overflow it, dump it
    task automatic fill_table();
        send_request(tvt_pkg::OP_FLUSH, pick_key(), pick_operand());
        repeat (TABLE_DEPTH) send_request(tvt_pkg::OP_SET, {$urandom, $urandom}, pick_operand());
        send_request(tvt_pkg::OP_ADD, {$urandom, $urandom}, pick_operand());
        send_request(tvt_pkg::OP_SET, {$urandom, $urandom}, pick_operand());
        send_request(tvt_pkg::OP_SNAPSHOT, pick_key(), pick_operand());
    endtask

    task automatic random_request();
        int         pick;
        logic [2:0] opcode;
        pick = $urandom_range(0, 99);
        if (pick < 25)      opcode = tvt_pkg::OP_SET;
        else if (pick < 50) opcode = tvt_pkg::OP_ADD;
        else if (pick < 65) opcode = tvt_pkg::OP_CLEAR;
        else if (pick < 85) opcode = tvt_pkg::OP_LOOKUP;
        else if (pick < 94) opcode = tvt_pkg::OP_SNAPSHOT;
        else if (pick < 97) opcode = tvt_pkg::OP_FLUSH;
        else                opcode = ($urandom_range(0, 1) == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
        send_request(opcode, pick_key(), pick_operand());
    endtask

    // stimulus
    initial begin : stimulus
        logic [63:0] key_a;
        logic [63:0] key_b;
        int          rand_start;
        int          done_cnt;
        int          next_mode_at;
        bit          hold_done;
        bit          pause_done;

        tvt_sb = new();
        key_pool[0] = '0;
        key_pool[1] = tvt_pkg::U64_MAX;
        for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
        key_a        = {$urandom, $urandom};
        key_b        = {$urandom, $urandom};
        next_mode_at = 0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corner cases
        send_request(tvt_pkg::OP_LOOKUP, '0, '0);                      // empty table
        send_request(tvt_pkg::OP_SNAPSHOT, '0, '0);                    // nothing present
        send_request(tvt_pkg::OP_CLEAR, key_a, '0);                    // clear of an unknown tag
        send_request(tvt_pkg::OP_SET, '0, tvt_pkg::U64_MAX);
        send_request(tvt_pkg::OP_ADD, tvt_pkg::U64_MAX, 64'd5);        // appended, starts at zero
        send_request(tvt_pkg::OP_ADD, '0, 64'd1);                      // saturates
        send_request(tvt_pkg::OP_CLEAR, tvt_pkg::U64_MAX, '0);
        send_request(tvt_pkg::OP_LOOKUP, tvt_pkg::U64_MAX, '0);        // cleared entry
        send_request(tvt_pkg::OP_SET, key_a, key_b);                   // takes the cleared slot
        send_request(tvt_pkg::OP_ADD, tvt_pkg::U64_MAX, tvt_pkg::U64_MAX); // appended again
        send_request(tvt_pkg::OP_CLEAR, key_a, '0);
        send_request(tvt_pkg::OP_ADD, key_a, 64'd9);                   // own cleared slot, from zero
        send_request(tvt_pkg::OP_LOOKUP, key_a, '0);
        send_request(tvt_pkg::OP_LOOKUP, '0, '0);
        send_request(tvt_pkg::OP_SNAPSHOT, key_b, key_a);              // three entries
        send_request(tvt_pkg::OP_CLEAR, tvt_pkg::U64_MAX, '0);
        send_request(tvt_pkg::OP_SNAPSHOT, '0, '0);                    // last flag before end slot
        send_request(OP_UNUSED_6, key_b, key_a);
        send_request(OP_UNUSED_7, tvt_pkg::U64_MAX, tvt_pkg::U64_MAX);
        send_request(tvt_pkg::OP_FLUSH, '0, '0);
        send_request(tvt_pkg::OP_LOOKUP, '0, '0);                      // gone after flush
        send_request(tvt_pkg::OP_SNAPSHOT, tvt_pkg::U64_MAX, '0);
        drain_results();

        // random traffic with table fills, a long output hold and a drain pause
        rand_start = items_sent;
        fill_table();
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            done_cnt = items_sent - rand_start;
            if (done_cnt >= next_mode_at) begin
                quiet_mode   = ($urandom_range(0, 3) == 0);
                next_mode_at = done_cnt + 30;
            end
            if (!hold_done && done_cnt >= 90) begin
                hold_done     = 1'b1;
                quiet_mode    = 1'b0;
                long_hold_req = 1'b1;
                burst_left    = 12;
                send_request(tvt_pkg::OP_SNAPSHOT, pick_key(), pick_operand());
            end else if (!pause_done && done_cnt >= 140) begin
                pause_done = 1'b1;
                drain_results();
                fill_table();
            end else begin
                random_request();
            end
        end

        drain_results();
        repeat (END_SETTLE) @(posedge i_clk);
        $display("covered %0d requests and %0d results over %0d cycles",
                 tvt_sb.requests_seen, tvt_sb.results_seen, cycle_count);
        $display("snapshot entries %0d, refused writes %0d, saturated adds %0d",
                 tvt_sb.snapshot_entries, tvt_sb.refused_writes, tvt_sb.saturated_adds);
        if (tvt_sb.errors == 0 && tvt_sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
